### rtl/core/bf_pkg.sv
// ----------------------------------------------------------------------------
// bf_pkg
// Shared types and constants for the Blowfish block encryption core.
// ----------------------------------------------------------------------------
package bf_pkg;

    // Field widths
    localparam int WORD_W = 32;
    localparam int IDX_W  = 10;
    localparam int REQ_W  = 2;
    localparam int BYTE_W = 8;

    // S-box geometry: four boxes of 256 words
    localparam int NUM_BOXES  = 4;
    localparam int BOX_DEPTH  = 256;
    localparam int BOX_SEL_W  = 2;

    // Default round count
    localparam int ROUNDS_DEF = 16;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_LOAD_P  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_LOAD_S  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_ENCRYPT = 2'd2;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load_p;   // write a P-array word
        logic load_s;   // write an S-box word
        logic start;    // take in a plaintext block, apply P[0]
        logic step;     // run one non-final round
        logic finish;   // run the final round, whiten, load output
    } bf_cmd_t;

endpackage

### rtl/core/blowfish_block_encrypt_top.sv
// ----------------------------------------------------------------------------
// blowfish_block_encrypt_top
// Blowfish block encryption core with host-loaded P-array and S-boxes.
// ----------------------------------------------------------------------------
// An encrypt word is taken in and whitened with P[0], then run through ROUNDS
// Feistel rounds, and the next word can be accepted in the first cycle the
// result is offered. The round loop runs one Feistel round per cycle on a
// registered read of the four S-box RAMs, but for the final-round stall below.
// P-array and S-box load words give no result and leave the core ready.
// A finished result sits in an output register, so loads and a new encrypt
// are taken while it waits; only the final round of the next encrypt stalls
// until it is taken.
// Tables are not cleared at reset and must be loaded before use.
module blowfish_block_encrypt_top #(
    parameter int ROUNDS = bf_pkg::ROUNDS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [bf_pkg::REQ_W-1:0]  s_req_type,
    input  logic [bf_pkg::IDX_W-1:0]  s_table_index,
    input  logic [bf_pkg::WORD_W-1:0] s_table_word,
    input  logic [bf_pkg::WORD_W-1:0] s_left_in,
    input  logic [bf_pkg::WORD_W-1:0] s_right_in,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [bf_pkg::WORD_W-1:0] m_left_out,
    output logic [bf_pkg::WORD_W-1:0] m_right_out
);
    import bf_pkg::*;

    localparam int CNT_W = $clog2(ROUNDS);

    bf_cmd_t          cmd;
    logic [CNT_W-1:0] rnd_cnt;

    bf_ctrl #(
        .ROUNDS (ROUNDS),
        .CNT_W  (CNT_W)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_req_type (s_req_type),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .cmd        (cmd),
        .rnd_cnt    (rnd_cnt)
    );

    bf_dpath #(
        .ROUNDS (ROUNDS),
        .CNT_W  (CNT_W)
    ) u_dpath (
        .aclk          (aclk),
        .cmd           (cmd),
        .rnd_cnt       (rnd_cnt),
        .s_table_index (s_table_index),
        .s_table_word  (s_table_word),
        .s_left_in     (s_left_in),
        .s_right_in    (s_right_in),
        .m_left_out    (m_left_out),
        .m_right_out   (m_right_out)
    );

endmodule

### rtl/core/bf_ctrl.sv
// ----------------------------------------------------------------------------
// bf_ctrl
// Controller: handshakes, round counter and output valid for the core.
// ----------------------------------------------------------------------------
module bf_ctrl #(
    parameter int ROUNDS = bf_pkg::ROUNDS_DEF,
    parameter int CNT_W  = $clog2(ROUNDS)
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [bf_pkg::REQ_W-1:0] s_req_type,
    output logic                     m_valid,
    input  logic                     m_ready,
    output bf_pkg::bf_cmd_t          cmd,
    output logic [CNT_W-1:0]         rnd_cnt
);
    import bf_pkg::*;

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_ROUND = 1'b1;
    localparam logic [CNT_W-1:0] LAST_RND = CNT_W'(ROUNDS - 1);

    logic             state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             m_valid_reg, m_valid_next;
    logic             s_acc;
    logic             out_free;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_acc    = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign rnd_cnt  = cnt_reg;

    // Next-state and command decode
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    cmd.load_p = (s_req_type == REQ_LOAD_P);
                    cmd.load_s = (s_req_type == REQ_LOAD_S);
                    if (s_req_type == REQ_ENCRYPT) begin
                        cmd.start  = 1'b1;
                        cnt_next   = '0;
                        state_next = ST_ROUND;
                    end
                end
            end
            ST_ROUND: begin
                if (cnt_reg != LAST_RND) begin
                    cmd.step = 1'b1;
                    cnt_next = cnt_reg + CNT_W'(1);
                end else if (out_free) begin
                    // final round waits here while the output word is held
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output valid: set on finish, cleared when taken
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.finish) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

### rtl/core/bf_dpath.sv
// ----------------------------------------------------------------------------
// bf_dpath
// Datapath: P-array registers, four S-box RAMs, round logic and output word.
// ----------------------------------------------------------------------------
module bf_dpath #(
    parameter int ROUNDS  = bf_pkg::ROUNDS_DEF,
    parameter int CNT_W   = $clog2(ROUNDS)
) (
    input  logic                      aclk,
    input  bf_pkg::bf_cmd_t           cmd,
    input  logic [CNT_W-1:0]          rnd_cnt,
    input  logic [bf_pkg::IDX_W-1:0]  s_table_index,
    input  logic [bf_pkg::WORD_W-1:0] s_table_word,
    input  logic [bf_pkg::WORD_W-1:0] s_left_in,
    input  logic [bf_pkg::WORD_W-1:0] s_right_in,
    output logic [bf_pkg::WORD_W-1:0] m_left_out,
    output logic [bf_pkg::WORD_W-1:0] m_right_out
);
    import bf_pkg::*;

    localparam int P_DEPTH = ROUNDS + 2;
    localparam int P_IDX_W = $clog2(P_DEPTH);

    // P-array, one register per word
    logic [WORD_W-1:0]  p_reg [P_DEPTH];
    // S-box RAMs and their registered read data
    logic [WORD_W-1:0]  s_mem [NUM_BOXES][BOX_DEPTH];
    logic [WORD_W-1:0]  s_rd_reg [NUM_BOXES];

    logic [WORD_W-1:0]  l_reg, l_next;
    logic [WORD_W-1:0]  r_reg, r_next;
    logic [WORD_W-1:0]  left_out_reg, left_out_next;
    logic [WORD_W-1:0]  right_out_reg, right_out_next;

    logic [P_IDX_W-1:0] p_sel;
    logic [WORD_W-1:0]  p_word;
    logic [WORD_W-1:0]  f_out;
    logic [WORD_W-1:0]  r_mix;
    logic               p_wr_ok;
    logic               s_rd_en;

    // P-array write, out-of-range index dropped
    assign p_wr_ok = (s_table_index < IDX_W'(P_DEPTH));

    always_ff @(posedge aclk) begin
        if (cmd.load_p && p_wr_ok) begin
            p_reg[s_table_index[P_IDX_W-1:0]] <= s_table_word;
        end
    end

    // P word for the round being entered: P[0] at start, P[cnt+1] per step
    assign p_sel  = cmd.start ? '0 : (P_IDX_W'(rnd_cnt) + P_IDX_W'(1));
    assign p_word = p_reg[p_sel];

    // Round function on registered S-box data
    assign f_out = ((s_rd_reg[0] + s_rd_reg[1]) ^ s_rd_reg[2]) + s_rd_reg[3];
    assign r_mix = r_reg ^ f_out;

    // Half-block update
    always_comb begin
        l_next = l_reg;
        r_next = r_reg;
        if (cmd.start) begin
            l_next = s_left_in ^ p_word;
            r_next = s_right_in;
        end else if (cmd.step) begin
            l_next = r_mix ^ p_word;
            r_next = l_reg;
        end
    end

    // Final round: swap undone, then whitening
    always_comb begin
        left_out_next  = left_out_reg;
        right_out_next = right_out_reg;
        if (cmd.finish) begin
            left_out_next  = l_reg ^ p_reg[ROUNDS + 1];
            right_out_next = r_mix ^ p_reg[ROUNDS];
        end
    end

    assign s_rd_en = cmd.start || cmd.step;

    // S-box RAMs: one write port shared by load, one read port per box
    always_ff @(posedge aclk) begin
        for (int b = 0; b < NUM_BOXES; b++) begin
            if (cmd.load_s && (s_table_index[IDX_W-1 -: BOX_SEL_W] == BOX_SEL_W'(b))) begin
                s_mem[b][s_table_index[BYTE_W-1:0]] <= s_table_word;
            end
            if (s_rd_en) begin
                s_rd_reg[b] <= s_mem[b][l_next[WORD_W-1-BYTE_W*b -: BYTE_W]];
            end
        end
    end

    always_ff @(posedge aclk) begin
        l_reg         <= l_next;
        r_reg         <= r_next;
        left_out_reg  <= left_out_next;
        right_out_reg <= right_out_next;
    end

    assign m_left_out  = left_out_reg;
    assign m_right_out = right_out_reg;

endmodule

### rtl/core/bf_checker.sv
// ----------------------------------------------------------------------------
// bf_checker
// Port-level checks for the Blowfish core, bound to the top level.
// ----------------------------------------------------------------------------
module bf_checker (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      s_valid,
    input logic                      s_ready,
    input logic [bf_pkg::REQ_W-1:0]  s_req_type,
    input logic                      m_valid,
    input logic                      m_ready,
    input logic [bf_pkg::WORD_W-1:0] m_left_out,
    input logic [bf_pkg::WORD_W-1:0] m_right_out
);
    import bf_pkg::*;

    // A held result stays valid
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result word dropped while stalled");

    // A held result keeps its value
    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_left_out) && $stable(m_right_out))
        else $error("result word changed while stalled");

    // An encrypt word occupies the core
    a_enc_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_req_type == REQ_ENCRYPT) |=> !s_ready)
        else $error("input taken during encryption");

    // Load and unused words leave the core ready
    a_load_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_req_type != REQ_ENCRYPT) |=> s_ready)
        else $error("core went busy on a non-encrypt word");

    // A new result appears only as the core returns to idle
    a_result_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> s_ready)
        else $error("result raised while core still busy");

endmodule

bind blowfish_block_encrypt_top bf_checker u_bf_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .s_req_type  (s_req_type),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_left_out  (m_left_out),
    .m_right_out (m_right_out)
);
